// ===== design/cpc_pkg.sv =====
`default_nettype none

package cpc_pkg;

  // Configuration register map.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_DEPTH    = 2'd3
  } cfg_idx_t;

  // Fixed field widths.
  localparam int RADIUS_W    = 16;
  localparam int DEPTH_CFG_W = 3;
  localparam int COV_W       = 13;

  // Coverage is reported in units of 1/4096.
  localparam int FULL_SHIFT = 12;
  localparam logic [COV_W-1:0] FULL_SCALE = 13'd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic diff;
    logic square;
    logic root;
    logic walk;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic reject;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/cpc_cfg.sv =====
`default_nettype none

module cpc_cfg #(
  parameter int COORD_BITS = 21,
  parameter int CFG_W      = 21
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_data,
  output logic signed [COORD_BITS-1:0]           center_x,
  output logic signed [COORD_BITS-1:0]           center_y,
  output logic [cpc_pkg::RADIUS_W-1:0]           radius,
  output logic [cpc_pkg::DEPTH_CFG_W-1:0]        depth_levels
);

  logic signed [COORD_BITS-1:0]         center_x_r;
  logic signed [COORD_BITS-1:0]         center_y_r;
  logic [cpc_pkg::RADIUS_W-1:0]         radius_r;
  logic [cpc_pkg::DEPTH_CFG_W-1:0]      depth_r;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes; bits above a register's width are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= 16'd256;
      depth_r    <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cpc_pkg::cfg_idx_t'(cfg_index))
        cpc_pkg::CFG_CENTER_X: center_x_r <= cfg_data[COORD_BITS-1:0];
        cpc_pkg::CFG_CENTER_Y: center_y_r <= cfg_data[COORD_BITS-1:0];
        cpc_pkg::CFG_RADIUS:   radius_r   <= cfg_data[cpc_pkg::RADIUS_W-1:0];
        cpc_pkg::CFG_DEPTH:    depth_r    <= cfg_data[cpc_pkg::DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign center_x     = center_x_r;
  assign center_y     = center_y_r;
  assign radius       = radius_r;
  assign depth_levels = depth_r;

endmodule

`default_nettype wire

// ===== design/cpc_ctrl.sv =====
`default_nettype none

module cpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output cpc_pkg::cmd_t      cmd,
  input  wire cpc_pkg::sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIFF   = 6'b000010,
    ST_SQUARE = 6'b000100,
    ST_ROOT   = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Sequence one pixel: offsets, squares, root node, sub-square walk, result.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = sts.reject ? ST_FIN : ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root  = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/cpc_dp.sv =====
`default_nettype none

module cpc_dp #(
  parameter int MAX_DEPTH  = 6,
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 21
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cpc_pkg::cmd_t                      cmd,
  output cpc_pkg::sts_t                           sts,
  input  wire logic signed [COORD_BITS-1:0]       in_pixel_x,
  input  wire logic signed [COORD_BITS-1:0]       in_pixel_y,
  input  wire logic signed [COORD_BITS-1:0]       center_x,
  input  wire logic signed [COORD_BITS-1:0]       center_y,
  input  wire logic [cpc_pkg::RADIUS_W-1:0]       radius,
  input  wire logic [cpc_pkg::DEPTH_CFG_W-1:0]    depth_levels,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [cpc_pkg::COV_W-1:0]               out_coverage
);

  // Offsets inside the walk carry EXT extra fraction bits, so every
  // sub-square offset and squared distance is an exact integer.
  localparam int EXT     = MAX_DEPTH + 1;
  localparam int DEP_W   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SQH     = ((46341 << FRAC_BITS) + 32768) >> 16;
  localparam int RP_W    = cpc_pkg::RADIUS_W + 1;
  localparam int DX_W    = (COORD_BITS + 1 > RP_W + 1) ? COORD_BITS + 1 : RP_W + 1;
  localparam int MAG_W   = RP_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int OFF_W   = RP_W + 2 + EXT;
  localparam int D2_W    = 2 * RP_W + 3 + 2 * EXT;
  localparam int SH_BASE = FRAC_BITS + EXT - 1;
  localparam int CNT_W   = 2 * MAX_DEPTH + 1;
  localparam int RND_W   = CNT_W + cpc_pkg::FULL_SHIFT;

  typedef struct packed {
    logic signed [OFF_W-1:0] x;
    logic signed [OFF_W-1:0] y;
    logic [D2_W-1:0]         d2;
  } node_t;

  // Child k of a square at remaining depth lvl. Children sit at +-s on each
  // axis, s = half a pixel / 2^lvl; the squared distance follows from the
  // parent's by shifts: d2 + 2s(+-x +-y) + 2s^2.
  function automatic node_t gen_child(
    input logic signed [OFF_W-1:0] px,
    input logic signed [OFF_W-1:0] py,
    input logic [D2_W-1:0]         pd2,
    input logic [DEP_W-1:0]        lvl,
    input logic [1:0]              k
  );
    int                      sh_s;
    logic signed [OFF_W-1:0] s;
    logic signed [OFF_W:0]   t;
    logic [D2_W+1:0]         term;
    logic [D2_W+1:0]         cterm;
    logic [D2_W+1:0]         sum;
    node_t                   c;
    sh_s  = SH_BASE - int'(lvl);
    s     = OFF_W'(1) <<< sh_s;
    c.x   = k[1] ? (px + s) : (px - s);
    c.y   = k[0] ? (py + s) : (py - s);
    t     = (k[1] ? (OFF_W+1)'(px) : -(OFF_W+1)'(px))
          + (k[0] ? (OFF_W+1)'(py) : -(OFF_W+1)'(py));
    term  = (D2_W+2)'(t) <<< (sh_s + 1);
    cterm = (D2_W+2)'(1) << (2 * sh_s + 1);
    sum   = (D2_W+2)'(pd2) + term + cterm;
    c.d2  = sum[D2_W-1:0];
    return c;
  endfunction

  logic signed [COORD_BITS-1:0] pix_x_r;
  logic signed [COORD_BITS-1:0] pix_y_r;
  logic signed [DX_W-1:0]       dx_full;
  logic signed [DX_W-1:0]       dy_full;
  logic [DX_W-1:0]              adx;
  logic [DX_W-1:0]              ady;
  logic [RP_W-1:0]              rplus;
  logic signed [RP_W:0]         rmin_s;
  logic                         reject;

  logic signed [RP_W:0]         dx_r;
  logic signed [RP_W:0]         dy_r;
  logic [MAG_W-1:0]             adx_r;
  logic [MAG_W-1:0]             ady_r;
  logic [DEP_W-1:0]             dep_r;
  logic [SQ_W-1:0]              sqx_r;
  logic [SQ_W-1:0]              sqy_r;
  logic [SQ_W-1:0]              rl_r;
  logic [SQ_W-1:0]              ro_r;
  logic [SQ_W-1:0]              ri_r;
  logic                         ri_en_r;

  logic signed [OFF_W-1:0]      cur_x_r;
  logic signed [OFF_W-1:0]      cur_y_r;
  logic [D2_W-1:0]              cur_d2_r;
  logic [DEP_W-1:0]             cur_d_r;
  logic [CNT_W-1:0]             acc_r;

  logic signed [OFF_W-1:0]      stk_x_r  [MAX_DEPTH];
  logic signed [OFF_W-1:0]      stk_y_r  [MAX_DEPTH];
  logic [D2_W-1:0]              stk_d2_r [MAX_DEPTH];
  logic [1:0]                   nxt_r    [MAX_DEPTH];

  logic [D2_W-1:0]              rl_w;
  logic [D2_W-1:0]              ro_w;
  logic [D2_W-1:0]              ri_w;
  logic                         is_leaf;
  logic                         out_hit;
  logic                         in_hit;
  logic                         terminal;
  logic [CNT_W-1:0]             value;
  logic                         found;
  logic [DEP_W-1:0]             lf;
  logic [DEP_W-1:0]             lf_m1;
  logic [DEP_W-1:0]             cur_m1;
  logic [IDX_W-1:0]             sidx;
  logic [IDX_W-1:0]             cidx;
  logic [DEP_W-1:0]             dep_sat;
  node_t                        child_a;
  node_t                        child_b;

  logic [RND_W-1:0]             rnd;
  logic [cpc_pkg::COV_W-1:0]    out_cov_r;
  logic                         out_valid_r;
  logic                         out_free;

  // Offsets from the center and the coarse bounding-box reject.
  assign dx_full = DX_W'(pix_x_r) - DX_W'(center_x);
  assign dy_full = DX_W'(pix_y_r) - DX_W'(center_y);
  assign adx     = dx_full[DX_W-1] ? DX_W'(-dx_full) : DX_W'(dx_full);
  assign ady     = dy_full[DX_W-1] ? DX_W'(-dy_full) : DX_W'(dy_full);
  assign rplus   = RP_W'(radius) + RP_W'(SQH);
  assign rmin_s  = (RP_W+1)'(radius) - (RP_W+1)'(SQH);
  assign reject  = (adx >= DX_W'(rplus)) || (ady >= DX_W'(rplus));
  assign dep_sat = (int'(depth_levels) > MAX_DEPTH) ? DEP_W'(MAX_DEPTH) : DEP_W'(depth_levels);

  // Radius thresholds scaled to the walk's fixed point.
  assign rl_w = D2_W'(rl_r) << (2 * EXT);
  assign ro_w = D2_W'(ro_r) << (2 * EXT);
  assign ri_w = D2_W'(ri_r) << (2 * EXT);

  // Classify the current sub-square.
  assign is_leaf  = (cur_d_r == '0);
  assign out_hit  = (cur_d2_r > ro_w);
  assign in_hit   = ri_en_r && (cur_d2_r <= ri_w);
  assign terminal = is_leaf || out_hit || in_hit;

  always_comb begin
    if (is_leaf) begin
      value = CNT_W'(cur_d2_r <= rl_w);
    end else if (out_hit || !in_hit) begin
      value = '0;
    end else begin
      value = CNT_W'(1) << {cur_d_r, 1'b0};
    end
  end

  // Nearest ancestor level that still has a child to visit.
  always_comb begin
    found = 1'b0;
    lf    = '0;
    for (int l = MAX_DEPTH; l >= 1; l--) begin
      if (l > int'(cur_d_r) && l <= int'(dep_r) && nxt_r[l-1] != 2'd0) begin
        found = 1'b1;
        lf    = DEP_W'(l);
      end
    end
  end

  assign lf_m1  = lf - DEP_W'(1);
  assign cur_m1 = cur_d_r - DEP_W'(1);
  assign sidx   = lf_m1[IDX_W-1:0];
  assign cidx   = cur_m1[IDX_W-1:0];

  // First child of the current square, and the next sibling up the stack.
  assign child_a = gen_child(cur_x_r, cur_y_r, cur_d2_r, cur_d_r, 2'd0);
  assign child_b = gen_child(stk_x_r[sidx], stk_y_r[sidx], stk_d2_r[sidx], lf, nxt_r[sidx]);

  // Pixel capture, offsets and squares.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_x_r <= in_pixel_x;
      pix_y_r <= in_pixel_y;
    end
    if (cmd.diff) begin
      dx_r  <= dx_full[RP_W:0];
      dy_r  <= dy_full[RP_W:0];
      adx_r <= adx[MAG_W-1:0];
      ady_r <= ady[MAG_W-1:0];
      dep_r <= dep_sat;
    end
    if (cmd.square) begin
      sqx_r   <= SQ_W'(adx_r) * SQ_W'(adx_r);
      sqy_r   <= SQ_W'(ady_r) * SQ_W'(ady_r);
      rl_r    <= SQ_W'(radius) * SQ_W'(radius);
      ro_r    <= SQ_W'(rplus) * SQ_W'(rplus);
      ri_r    <= SQ_W'(rmin_s[RP_W-1:0]) * SQ_W'(rmin_s[RP_W-1:0]);
      ri_en_r <= (rmin_s > (RP_W+1)'(0));
    end
  end

  // Sub-square walk: one square per cycle, explicit stack of parents.
  always_ff @(posedge clk) begin
    if (cmd.root) begin
      cur_x_r  <= OFF_W'(dx_r) <<< EXT;
      cur_y_r  <= OFF_W'(dy_r) <<< EXT;
      cur_d2_r <= D2_W'((SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqy_r)) << (2 * EXT);
      cur_d_r  <= dep_r;
    end else if (cmd.walk) begin
      if (!terminal) begin
        stk_x_r[cidx]  <= cur_x_r;
        stk_y_r[cidx]  <= cur_y_r;
        stk_d2_r[cidx] <= cur_d2_r;
        nxt_r[cidx]    <= 2'd1;
        cur_x_r        <= child_a.x;
        cur_y_r        <= child_a.y;
        cur_d2_r       <= child_a.d2;
        cur_d_r        <= cur_m1;
      end else if (found) begin
        nxt_r[sidx]    <= nxt_r[sidx] + 2'd1;
        cur_x_r        <= child_b.x;
        cur_y_r        <= child_b.y;
        cur_d2_r       <= child_b.d2;
        cur_d_r        <= lf_m1;
      end
    end
  end

  // Coverage count in units of 1/4^depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.capture) begin
      acc_r <= '0;
    end else if (cmd.walk) begin
      acc_r <= acc_r + value;
    end
  end

  // Rescale to 1/4096 with rounding.
  assign rnd = ((RND_W'(acc_r) << cpc_pkg::FULL_SHIFT)
             + ((RND_W'(1) << {dep_r, 1'b0}) >> 1)) >> {dep_r, 1'b0};

  // Output register; the next pixel proceeds while a result waits here.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_cov_r   <= '0;
    end else if (cmd.finish && out_free) begin
      out_valid_r <= 1'b1;
      out_cov_r   <= rnd[cpc_pkg::COV_W-1:0];
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.reject    = reject;
  assign sts.walk_done = terminal && !found;
  assign sts.out_free  = out_free;

  assign out_valid    = out_valid_r;
  assign out_coverage = out_cov_r;

endmodule

`default_nettype wire

// ===== design/circle_pixel_coverage_top.sv =====
`default_nettype none

// Returns the fraction of one pixel covered by a circle, in units of 1/4096.
// Center, radius and subdivision depth come from the configuration port;
// the user must write them only while the block is idle, which the block
// does not enforce. A pixel lying outside the circle's bounding box by the
// half-diagonal gives 0 and skips the walk. Any other pixel passes the
// offset, square and root steps and the quadrant walk, which handles one
// sub-square per cycle and visits at most (4^(depth+1) - 1)/3 of them (85
// at depth 3; fully inside or outside pixels finish after one sub-square).
// One pixel is processed at a time; the next is accepted as soon as the
// previous result sits in the output register, whether or not it was taken.
module circle_pixel_coverage_top #(
  parameter int MAX_DEPTH  = 6,
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 21,
  localparam int CFG_W = (COORD_BITS > cpc_pkg::RADIUS_W) ? COORD_BITS : cpc_pkg::RADIUS_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]                cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [COORD_BITS-1:0]    in_pixel_x,
  input  wire logic signed [COORD_BITS-1:0]    in_pixel_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [cpc_pkg::COV_W-1:0]            out_coverage
);

  logic signed [COORD_BITS-1:0]        center_x;
  logic signed [COORD_BITS-1:0]        center_y;
  logic [cpc_pkg::RADIUS_W-1:0]        radius;
  logic [cpc_pkg::DEPTH_CFG_W-1:0]     depth_levels;
  cpc_pkg::cmd_t                       cmd;
  cpc_pkg::sts_t                       sts;

  cpc_cfg #(
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .depth_levels (depth_levels)
  );

  cpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cpc_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .depth_levels (depth_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_coverage (out_coverage)
  );

`ifndef SYNTHESIS
  // A result never exceeds a fully covered pixel.
  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coverage <= cpc_pkg::FULL_SCALE))
    else $error("coverage above full scale");

  // An accepted pixel goes straight to the offset stage.
  a_accept_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.diff)
    else $error("accepted pixel did not start");

  // A rejected pixel skips the walk.
  a_reject_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.diff && sts.reject) |=> cmd.finish)
    else $error("rejected pixel did not finish at once");

  // A finished pixel with a free output register shows a result next cycle.
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && sts.out_free) |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
